### rtl/qsl_pkg.sv
// Shared command and status types between the sort controller and datapath.
package qsl_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic load_wr;      // store the incoming item at the fill count
        logic clr_count;    // run delivered, restart the fill count
        logic push_full;    // push the whole run as the first range
        logic push_left;    // push the range left of the pivot
        logic push_right;   // push the range right of the pivot
        logic pop;          // read the top range, drop the stack pointer
        logic latch_range;  // take low and high bounds from the popped entry
        logic rd_hi;        // read the pivot slot
        logic piv_load;     // hold the pivot, set scan and boundary to low
        logic scan_rd;      // read the scan and boundary slots
        logic swap_a;       // write scanned value to the boundary slot
        logic swap_b;       // write boundary value to the scan slot
        logic adv_both;     // advance scan and boundary
        logic adv_scan;     // advance scan only
        logic emit_clr;     // start output at slot zero
        logic emit_rd;      // read the next output slot
        logic emit_load;    // move read data into the output register
    } qsl_cmd_t;

    typedef struct packed {
        logic count_ge2;
        logic last_slot;
        logic sp_zero;
        logic range_bad;
        logic le;
        logic scan_at_hi;
        logic push_left_ok;
        logic push_right_ok;
        logic emit_last;
        logic out_free;
    } qsl_status_t;

endpackage

### rtl/qsl_dp.sv
// Sort datapath: element store, range stack, index registers and output register.
module qsl_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  qsl_pkg::qsl_cmd_t          cmd,
    output qsl_pkg::qsl_status_t       status,
    input  logic [qsl_pkg::DATA_W-1:0] in_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [qsl_pkg::DATA_W-1:0] out_value,
    output logic                       out_last
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = qsl_pkg::DATA_W;

    logic [DW-1:0]   elem_mem [CAPACITY];
    logic [2*IW-1:0] stack_mem [CAPACITY];

    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   sp_reg, sp_next;
    logic [IW-1:0]   lo_reg, hi_reg, scan_reg, bnd_reg, k_reg;
    logic [DW-1:0]   pivot_reg, rda_reg, rdb_reg;
    logic [2*IW-1:0] stk_rd_reg;
    logic            out_valid_reg;
    logic [DW-1:0]   out_value_reg;
    logic            out_last_reg;

    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    logic [DW-1:0]   mem_wdata;
    logic            rd_a_en;
    logic [IW-1:0]   rd_a_addr;
    logic            stk_we;
    logic [2*IW-1:0] stk_wdata;
    logic [CW-1:0]   sp_minus1;
    logic [CW-1:0]   count_minus1;

    assign sp_minus1    = sp_reg - CW'(1);
    assign count_minus1 = count_reg - CW'(1);

    always_comb
    begin
        mem_we    = cmd.load_wr | cmd.swap_a | cmd.swap_b;
        mem_waddr = count_reg[IW-1:0];
        mem_wdata = in_value;
        if (cmd.swap_a)
        begin
            mem_waddr = bnd_reg;
            mem_wdata = rda_reg;
        end
        else if (cmd.swap_b)
        begin
            mem_waddr = scan_reg;
            mem_wdata = rdb_reg;
        end
    end

    assign rd_a_en   = cmd.rd_hi | cmd.scan_rd | cmd.emit_rd;
    assign rd_a_addr = cmd.rd_hi ? hi_reg : (cmd.scan_rd ? scan_reg : k_reg);

    always_comb
    begin
        stk_we    = cmd.push_full | cmd.push_left | cmd.push_right;
        stk_wdata = {IW'(0), count_minus1[IW-1:0]};
        if (cmd.push_left)
            stk_wdata = {lo_reg, bnd_reg - IW'(1)};
        else if (cmd.push_right)
            stk_wdata = {bnd_reg + IW'(1), hi_reg};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            elem_mem[mem_waddr] <= mem_wdata;
        if (rd_a_en)
            rda_reg <= elem_mem[rd_a_addr];
        if (cmd.scan_rd)
            rdb_reg <= elem_mem[bnd_reg];
        if (stk_we)
            stack_mem[sp_reg[IW-1:0]] <= stk_wdata;
        if (cmd.pop)
            stk_rd_reg <= stack_mem[sp_minus1[IW-1:0]];
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr_count)
            count_next = '0;
        else if (cmd.load_wr)
            count_next = count_reg + CW'(1);
        sp_next = sp_reg;
        if (stk_we)
            sp_next = sp_reg + CW'(1);
        else if (cmd.pop)
            sp_next = sp_minus1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sp_reg    <= sp_next;
            if (cmd.emit_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_range)
        begin
            lo_reg <= stk_rd_reg[2*IW-1:IW];
            hi_reg <= stk_rd_reg[IW-1:0];
        end
        if (cmd.piv_load)
        begin
            pivot_reg <= rda_reg;
            bnd_reg   <= lo_reg;
            scan_reg  <= lo_reg;
        end
        else if (cmd.adv_both)
        begin
            bnd_reg  <= bnd_reg + IW'(1);
            scan_reg <= scan_reg + IW'(1);
        end
        else if (cmd.adv_scan)
            scan_reg <= scan_reg + IW'(1);
        if (cmd.emit_clr)
            k_reg <= '0;
        else if (cmd.emit_load)
            k_reg <= k_reg + IW'(1);
        if (cmd.emit_load)
        begin
            out_value_reg <= rda_reg;
            out_last_reg  <= status.emit_last;
        end
    end

    always_comb
    begin
        status.count_ge2     = count_reg >= CW'(2);
        status.last_slot     = count_reg == CW'(CAPACITY - 1);
        status.sp_zero       = sp_reg == '0;
        status.range_bad     = (lo_reg >= hi_reg) || (CW'(hi_reg) >= count_reg);
        status.le            = $signed(rda_reg) <= $signed(pivot_reg);
        status.scan_at_hi    = scan_reg == hi_reg;
        // q is the boundary once the pivot has landed
        status.push_left_ok  = (IW+1)'(bnd_reg) >= (IW+1)'(lo_reg) + (IW+1)'(2);
        status.push_right_ok = (IW+1)'(bnd_reg) + (IW+1)'(2) <= (IW+1)'(hi_reg);
        status.emit_last     = CW'(k_reg) + CW'(1) == count_reg;
        status.out_free      = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

### rtl/qsl_ctrl.sv
// Sort controller: load, partition, stack and emit sequencing.
module qsl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  qsl_pkg::qsl_status_t status,
    output qsl_pkg::qsl_cmd_t    cmd
);

    typedef enum logic [12:0] {
        S_LOAD  = 13'b0000000000001,
        S_INIT  = 13'b0000000000010,
        S_POP   = 13'b0000000000100,
        S_POPW  = 13'b0000000001000,
        S_CHK   = 13'b0000000010000,
        S_PIV   = 13'b0000000100000,
        S_SRD   = 13'b0000001000000,
        S_SCMP  = 13'b0000010000000,
        S_SWB   = 13'b0000100000000,
        S_PUSHL = 13'b0001000000000,
        S_PUSHR = 13'b0010000000000,
        S_ERD   = 13'b0100000000000,
        S_EWAIT = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_wr = 1'b1;
                    if (in_last || status.last_slot)
                        state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.push_full = status.count_ge2;
                state_next    = S_POP;
            end
            S_POP:
            begin
                if (status.sp_zero)
                begin
                    cmd.emit_clr = 1'b1;
                    state_next   = S_ERD;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                cmd.latch_range = 1'b1;
                state_next      = S_CHK;
            end
            S_CHK:
            begin
                if (status.range_bad)
                    state_next = S_POP;
                else
                begin
                    cmd.rd_hi  = 1'b1;
                    state_next = S_PIV;
                end
            end
            S_PIV:
            begin
                cmd.piv_load = 1'b1;
                state_next   = S_SRD;
            end
            S_SRD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCMP;
            end
            S_SCMP:
            begin
                // the pivot slot itself always compares true: final swap
                if (status.le)
                begin
                    cmd.swap_a = 1'b1;
                    state_next = S_SWB;
                end
                else
                begin
                    cmd.adv_scan = 1'b1;
                    state_next   = S_SRD;
                end
            end
            S_SWB:
            begin
                cmd.swap_b = 1'b1;
                if (status.scan_at_hi)
                    state_next = S_PUSHL;
                else
                begin
                    cmd.adv_both = 1'b1;
                    state_next   = S_SRD;
                end
            end
            S_PUSHL:
            begin
                cmd.push_left = status.push_left_ok;
                state_next    = S_PUSHR;
            end
            S_PUSHR:
            begin
                cmd.push_right = status.push_right_ok;
                state_next     = S_POP;
            end
            S_ERD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EWAIT;
            end
            S_EWAIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_last)
                    begin
                        cmd.clr_count = 1'b1;
                        state_next    = S_LOAD;
                    end
                    else
                        state_next = S_ERD;
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/quicksort_lomuto.sv
// Top level: run loader, Lomuto quicksort engine and sorted-run emitter.
//
//   channel   direction  tdata              tlast
//   s_axis    in         value [31:0]       last
//   m_axis    out        sorted_value[31:0] final_res
//
// Loading accepts one item per cycle. Sorting runs on one element store with a
// single write port: each scanned element is read and compared, and a swapped
// one takes a second write; each partition adds a stack pop, a pivot read and
// pushes. Output reads one item at a time through the element store read port.
// s_axis_tready is low from the closing item until the last result is in the
// output register; a stalled m_axis holds the emitter. Reset clears control only.
module quicksort_lomuto #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
    output logic        m_axis_tlast
);

    qsl_pkg::qsl_cmd_t    cmd;
    qsl_pkg::qsl_status_t status;

    qsl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qsl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_value  (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

### dv/quicksort_lomuto_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Lomuto quicksort block against a sort scoreboard.
module quicksort_lomuto_test;

    localparam int CAPACITY     = 64;
    localparam int TOTAL_ITEMS  = 360;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 600;

    typedef enum int {
        PAT_RANDOM,
        PAT_FEW,
        PAT_ASCEND,
        PAT_DESCEND,
        PAT_CONST,
        PAT_EXTREME
    } run_pattern_e;

    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_e;

    // Collects each open run and queues its sorted values once the run closes.
    class sort_scoreboard;
        logic signed [31:0] open_run[$];
        logic signed [31:0] sorted_values[$];
        logic               sorted_final[$];
        int                 errors;
        int                 accepted;

        function new();
            errors   = 0;
            accepted = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return sorted_values.size();
        endfunction

        function void close_run();
            logic signed [31:0] run_arr[CAPACITY];
            logic signed [31:0] key;
            int                 n;
            int                 j;
            n = open_run.size();
            for (int i = 0; i < n; i++)
                run_arr[i] = open_run[i];
            // insertion sort, ascending by signed value
            for (int i = 1; i < n; i++)
            begin
                key = run_arr[i];
                j   = i - 1;
                while (j >= 0 && run_arr[j] > key)
                begin
                    run_arr[j + 1] = run_arr[j];
                    j--;
                end
                run_arr[j + 1] = key;
            end
            for (int i = 0; i < n; i++)
            begin
                sorted_values.push_back(run_arr[i]);
                sorted_final.push_back(i == n - 1);
            end
            open_run.delete();
        endfunction

        function void note_input(logic [31:0] value, logic last);
            accepted++;
            open_run.push_back(signed'(value));
            // a full store closes the run exactly like a marked item
            if (last || open_run.size() == CAPACITY)
                close_run();
        endfunction

        task check_result(logic [31:0] value, logic final_res);
            logic signed [31:0] want_value;
            logic               want_final;
            if (sorted_values.size() == 0)
            begin
                report($sformatf("unexpected item value=%0d last=%0b",
                                 signed'(value), final_res));
            end
            else
            begin
                want_value = sorted_values.pop_front();
                want_final = sorted_final.pop_front();
                if (signed'(value) !== want_value)
                    report($sformatf("sorted_value got %0d want %0d",
                                     signed'(value), want_value));
                if (final_res !== want_final)
                    report($sformatf("final_res got %0b want %0b", final_res, want_final));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = 32'h0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    sort_scoreboard sb = new();

    logic [31:0] stim_value[$];
    logic        stim_last[$];

    quicksort_lomuto #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tdata, s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return 32'h0000_0001;
        endcase
    endfunction

    task automatic add_item(logic [31:0] value, logic last);
        stim_value.push_back(value);
        stim_last.push_back(last);
    endtask

    task automatic add_run(int len, run_pattern_e pat, bit mark_last);
        logic [31:0] base;
        logic [31:0] stride;
        logic [31:0] value;
        base   = $urandom;
        stride = $urandom_range(1, 1000);
        for (int i = 0; i < len; i++)
        begin
            case (pat)
                PAT_RANDOM:  value = $urandom;
                PAT_FEW:     value = base + $urandom_range(0, 3);
                PAT_ASCEND:  value = base + 32'(i) * stride;
                PAT_DESCEND: value = base - 32'(i) * stride;
                PAT_CONST:   value = base;
                default:     value = extreme_value();
            endcase
            add_item(value, mark_last && (i == len - 1));
        end
    endtask

    task automatic build_stimulus();
        run_pattern_e pat;
        int           len;
        // directed: single-element runs at both extremes
        add_item(32'h8000_0000, 1'b1);
        add_item(32'h7fff_ffff, 1'b1);
        // two elements, reversed
        add_item(32'h7fff_ffff, 1'b0);
        add_item(32'h8000_0000, 1'b1);
        // equal elements
        add_item(32'd5, 1'b0);
        add_item(32'd5, 1'b0);
        add_item(32'd5, 1'b1);
        // already sorted, then reversed
        for (int i = 1; i <= 4; i++)
            add_item(32'(i), i == 4);
        for (int i = 4; i >= 1; i--)
            add_item(32'(i), i == 1);
        // mixed signs around zero
        add_item(32'h7fff_ffff, 1'b0);
        add_item(32'h8000_0000, 1'b0);
        add_item(32'h0000_0000, 1'b0);
        add_item(32'hffff_ffff, 1'b0);
        add_item(32'h0000_0001, 1'b1);

        // full store without a mark, then full store with the mark on the closing item
        add_run(CAPACITY, PAT_RANDOM, 1'b0);
        add_run(CAPACITY, PAT_ASCEND, 1'b1);
        while (stim_value.size() < TOTAL_ITEMS)
        begin
            pat = run_pattern_e'($urandom_range(0, 5));
            if ($urandom_range(0, 19) == 0)
                len = CAPACITY;
            else
                len = $urandom_range(1, 10);
            add_run(len, pat, (len < CAPACITY) || ($urandom_range(0, 1) == 1));
        end
    endtask

    task automatic send_item(logic [31:0] value, logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // receiver: stall patterns of varying length, plus long holds to back up the input
    initial
    begin
        rx_mode_e mode;
        int       span;
        int       holds;
        holds = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (holds < 2 && sb.accepted >= 120 + 130 * holds)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds++;
            end
            mode = rx_mode_e'($urandom_range(0, 3));
            span = $urandom_range(5, 80);
            repeat (span)
            begin
                case (mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // sender: bursts of items with random gaps, then drain and verdict
    initial
    begin
        int burst;
        int gap;
        int idx;
        build_stimulus();
        wait (rst_n);
        @(posedge clk);
        idx = 0;
        while (idx < stim_value.size())
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && idx < stim_value.size())
            begin
                send_item(stim_value[idx], stim_last[idx]);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        // let the monitor note the closing item before looking at the queue
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d sorted items never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
